>>> hdl/ptt_pkg.sv
// Shared types, widths and constants for the pressure traction pipeline.
package ptt_pkg;

  localparam int ID_WIDTH = 32;
  localparam int COORD_WIDTH = 32;
  localparam int PRESSURE_WIDTH = 32;

  localparam int EDGE_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * EDGE_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int MANT_WIDTH = 31;
  localparam int SUM_WIDTH = 2 * MANT_WIDTH + 2;
  localparam int ROOT_WIDTH = SUM_WIDTH / 2;
  localparam int UNIT_SHIFT = 30;
  localparam int QUOT_WIDTH = UNIT_SHIFT + 1;
  localparam int DIVIDEND_WIDTH = MANT_WIDTH + UNIT_SHIFT;
  localparam int DIFF_WIDTH = PRESSURE_WIDTH + 1;
  localparam int TRAC_PROD_WIDTH = DIFF_WIDTH + QUOT_WIDTH;
  localparam int MAG_WIDTH = TRAC_PROD_WIDTH + 1 - UNIT_SHIFT;
  localparam int GROUP_WIDTH = 8;
  localparam int GROUP_COUNT = (CROSS_WIDTH + GROUP_WIDTH - 1) / GROUP_WIDTH;
  localparam int GPOS_WIDTH = $clog2(GROUP_WIDTH);
  localparam int LEN_WIDTH = $clog2(CROSS_WIDTH + 1);

  localparam logic [MAG_WIDTH-1:0] LIM_POS =
    MAG_WIDTH'((65'd1 << (PRESSURE_WIDTH - 1)) - 65'd1);
  localparam logic [MAG_WIDTH-1:0] LIM_NEG = MAG_WIDTH'(65'd1 << (PRESSURE_WIDTH - 1));
  localparam logic signed [PRESSURE_WIDTH-1:0] TRAC_MAX = {1'b0, {(PRESSURE_WIDTH-1){1'b1}}};
  localparam logic signed [PRESSURE_WIDTH-1:0] TRAC_MIN = {1'b1, {(PRESSURE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]              point_id;
    logic signed [COORD_WIDTH-1:0]    v0_x;
    logic signed [COORD_WIDTH-1:0]    v0_y;
    logic signed [COORD_WIDTH-1:0]    v0_z;
    logic signed [COORD_WIDTH-1:0]    v1_x;
    logic signed [COORD_WIDTH-1:0]    v1_y;
    logic signed [COORD_WIDTH-1:0]    v1_z;
    logic signed [COORD_WIDTH-1:0]    v2_x;
    logic signed [COORD_WIDTH-1:0]    v2_y;
    logic signed [COORD_WIDTH-1:0]    v2_z;
    logic signed [PRESSURE_WIDTH-1:0] pressure_negative;
    logic signed [PRESSURE_WIDTH-1:0] pressure_positive;
  } point_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]              result_id;
    logic signed [PRESSURE_WIDTH-1:0] traction_x;
    logic signed [PRESSURE_WIDTH-1:0] traction_y;
    logic signed [PRESSURE_WIDTH-1:0] traction_z;
    status_t                          status;
  } result_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   id;
    logic [DIFF_WIDTH-1:0] dmag;
    logic                  dneg;
    logic [2:0]            cneg;
    logic                  deg;
  } side_t;

  typedef struct packed {
    side_t                       side;
    logic [2:0][MANT_WIDTH-1:0]  m;
  } norm_t;

endpackage

>>> hdl/ptt_front.sv
// Front pipeline: edges, cross product, magnitude, normalization and sum of squares.
module ptt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  ptt_pkg::point_t               in_item,
  output logic                          out_valid,
  output logic [ptt_pkg::SUM_WIDTH-1:0] sum,
  output ptt_pkg::norm_t                out_norm
);
  import ptt_pkg::*;

  localparam int STAGES = 9;

  logic [STAGES-1:0] vld;

  logic signed [EDGE_WIDTH-1:0] e1_next [3];
  logic signed [EDGE_WIDTH-1:0] e2_next [3];
  logic signed [DIFF_WIDTH-1:0] diff_next;
  logic signed [EDGE_WIDTH-1:0] s1_e1 [3];
  logic signed [EDGE_WIDTH-1:0] s1_e2 [3];
  logic [ID_WIDTH-1:0]          s1_id;
  logic signed [DIFF_WIDTH-1:0] s1_diff;

  logic signed [PROD_WIDTH-1:0] s2_p [6];
  side_t                        s2_side;

  logic signed [CROSS_WIDTH-1:0] s3_c [3];
  side_t                         s3_side;

  logic [CROSS_WIDTH-1:0] s4_cm [3];
  side_t                  s4_side;

  logic [GROUP_COUNT-1:0] nz_next;
  logic [GPOS_WIDTH-1:0]  pos_next [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] s5_nz;
  logic [GPOS_WIDTH-1:0]  s5_pos [GROUP_COUNT];
  logic [CROSS_WIDTH-1:0] s5_cm [3];
  side_t                  s5_side;

  logic [LEN_WIDTH-1:0]   blen_next;
  logic [LEN_WIDTH-1:0]   s6_blen;
  logic [CROSS_WIDTH-1:0] s6_cm [3];
  side_t                  s6_side;

  logic [2:0][MANT_WIDTH-1:0] m_next;
  logic [2:0][MANT_WIDTH-1:0] s7_m;
  side_t                      s7_side;

  logic [2*MANT_WIDTH-1:0] s8_q [3];
  norm_t                   s8_norm;

  always_comb begin
    e1_next[0] = {in_item.v1_x[COORD_WIDTH-1], in_item.v1_x}
               - {in_item.v0_x[COORD_WIDTH-1], in_item.v0_x};
    e1_next[1] = {in_item.v1_y[COORD_WIDTH-1], in_item.v1_y}
               - {in_item.v0_y[COORD_WIDTH-1], in_item.v0_y};
    e1_next[2] = {in_item.v1_z[COORD_WIDTH-1], in_item.v1_z}
               - {in_item.v0_z[COORD_WIDTH-1], in_item.v0_z};
    e2_next[0] = {in_item.v2_x[COORD_WIDTH-1], in_item.v2_x}
               - {in_item.v0_x[COORD_WIDTH-1], in_item.v0_x};
    e2_next[1] = {in_item.v2_y[COORD_WIDTH-1], in_item.v2_y}
               - {in_item.v0_y[COORD_WIDTH-1], in_item.v0_y};
    e2_next[2] = {in_item.v2_z[COORD_WIDTH-1], in_item.v2_z}
               - {in_item.v0_z[COORD_WIDTH-1], in_item.v0_z};
    diff_next = {in_item.pressure_negative[PRESSURE_WIDTH-1], in_item.pressure_negative}
              - {in_item.pressure_positive[PRESSURE_WIDTH-1], in_item.pressure_positive};
  end

  always_comb begin
    logic [GROUP_COUNT*GROUP_WIDTH-1:0] cor;
    cor = (GROUP_COUNT*GROUP_WIDTH)'(s4_cm[0] | s4_cm[1] | s4_cm[2]);
    for (int g = 0; g < GROUP_COUNT; g++) begin
      nz_next[g] = |cor[g*GROUP_WIDTH +: GROUP_WIDTH];
      pos_next[g] = '0;
      for (int j = 0; j < GROUP_WIDTH; j++) begin
        if (cor[g*GROUP_WIDTH + j]) begin
          pos_next[g] = GPOS_WIDTH'(j);
        end
      end
    end
  end

  always_comb begin
    blen_next = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      if (s5_nz[g]) begin
        blen_next = LEN_WIDTH'(g*GROUP_WIDTH) + LEN_WIDTH'(s5_pos[g]) + LEN_WIDTH'(1);
      end
    end
  end

  always_comb begin
    logic [CROSS_WIDTH+MANT_WIDTH-1:0] wide;
    logic [CROSS_WIDTH+MANT_WIDTH-1:0] shifted;
    for (int i = 0; i < 3; i++) begin
      wide = {s6_cm[i], {MANT_WIDTH{1'b0}}};
      shifted = wide >> s6_blen;
      m_next[i] = shifted[MANT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1[i] <= e1_next[i];
        s1_e2[i] <= e2_next[i];
      end
      s1_id <= in_item.point_id;
      s1_diff <= diff_next;

      s2_p[0] <= s1_e1[1] * s1_e2[2];
      s2_p[1] <= s1_e1[2] * s1_e2[1];
      s2_p[2] <= s1_e1[2] * s1_e2[0];
      s2_p[3] <= s1_e1[0] * s1_e2[2];
      s2_p[4] <= s1_e1[0] * s1_e2[1];
      s2_p[5] <= s1_e1[1] * s1_e2[0];
      s2_side.id <= s1_id;
      s2_side.dmag <= s1_diff[DIFF_WIDTH-1] ? (DIFF_WIDTH'(0) - s1_diff) : s1_diff;
      s2_side.dneg <= s1_diff[DIFF_WIDTH-1];
      s2_side.cneg <= '0;
      s2_side.deg <= 1'b0;

      for (int i = 0; i < 3; i++) begin
        s3_c[i] <= {s2_p[2*i][PROD_WIDTH-1], s2_p[2*i]}
                 - {s2_p[2*i+1][PROD_WIDTH-1], s2_p[2*i+1]};
      end
      s3_side <= s2_side;

      s4_side.id <= s3_side.id;
      s4_side.dmag <= s3_side.dmag;
      s4_side.dneg <= s3_side.dneg;
      s4_side.deg <= s3_side.deg;
      for (int i = 0; i < 3; i++) begin
        s4_cm[i] <= s3_c[i][CROSS_WIDTH-1] ? (CROSS_WIDTH'(0) - s3_c[i]) : s3_c[i];
        s4_side.cneg[i] <= s3_c[i][CROSS_WIDTH-1];
      end

      s5_nz <= nz_next;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        s5_pos[g] <= pos_next[g];
      end
      for (int i = 0; i < 3; i++) begin
        s5_cm[i] <= s4_cm[i];
        s6_cm[i] <= s5_cm[i];
      end
      s5_side <= s4_side;

      s6_blen <= blen_next;
      s6_side.id <= s5_side.id;
      s6_side.dmag <= s5_side.dmag;
      s6_side.dneg <= s5_side.dneg;
      s6_side.cneg <= s5_side.cneg;
      s6_side.deg <= ~(|s5_nz);

      s7_m <= m_next;
      s7_side <= s6_side;

      for (int i = 0; i < 3; i++) begin
        s8_q[i] <= s7_m[i] * s7_m[i];
      end
      s8_norm.side <= s7_side;
      s8_norm.m <= s7_m;

      sum <= SUM_WIDTH'(s8_q[0]) + SUM_WIDTH'(s8_q[1]) + SUM_WIDTH'(s8_q[2]);
      out_norm <= s8_norm;
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

>>> hdl/ptt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ptt_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [ptt_pkg::SUM_WIDTH-1:0]  x,
  input  ptt_pkg::norm_t                 in_norm,
  output logic                           out_valid,
  output logic [ptt_pkg::ROOT_WIDTH-1:0] root,
  output ptt_pkg::norm_t                 out_norm
);
  import ptt_pkg::*;

  logic [ROOT_WIDTH-1:0] vld;
  logic [SUM_WIDTH-1:0]  rem_q [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] root_q [ROOT_WIDTH];
  norm_t                 norm_q [ROOT_WIDTH];
  logic [SUM_WIDTH-1:0]  rem_next [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] root_next [ROOT_WIDTH];

  always_comb begin
    logic [SUM_WIDTH-1:0]  r_in;
    logic [SUM_WIDTH-1:0]  trial;
    logic [ROOT_WIDTH-1:0] q_in;
    for (int k = 0; k < ROOT_WIDTH; k++) begin
      if (k == 0) begin
        r_in = x;
        q_in = '0;
      end else begin
        r_in = rem_q[k-1];
        q_in = root_q[k-1];
      end
      trial = (SUM_WIDTH'(q_in) << (ROOT_WIDTH - k))
            | (SUM_WIDTH'(1) << (2 * (ROOT_WIDTH - 1 - k)));
      if (r_in >= trial) begin
        rem_next[k] = r_in - trial;
        root_next[k] = q_in | (ROOT_WIDTH'(1) << (ROOT_WIDTH - 1 - k));
      end else begin
        rem_next[k] = r_in;
        root_next[k] = q_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_WIDTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_WIDTH; k++) begin
        rem_q[k] <= rem_next[k];
        root_q[k] <= root_next[k];
        norm_q[k] <= (k == 0) ? in_norm : norm_q[k-1];
      end
    end
  end

  assign out_valid = vld[ROOT_WIDTH-1];
  assign root = root_q[ROOT_WIDTH-1];
  assign out_norm = norm_q[ROOT_WIDTH-1];

`ifndef SYNTHESIS
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rem_q[ROOT_WIDTH-1] <= SUM_WIDTH'({root, 1'b0}))
    else $error("square root remainder exceeds twice the root");
`endif

endmodule

>>> hdl/ptt_div.sv
// Pipelined restoring divider for the three unit normal components.
module ptt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ptt_pkg::ROOT_WIDTH-1:0]      len,
  input  ptt_pkg::norm_t                      in_norm,
  output logic                                out_valid,
  output logic [2:0][ptt_pkg::QUOT_WIDTH-1:0] quo,
  output ptt_pkg::side_t                      out_side
);
  import ptt_pkg::*;

  logic [QUOT_WIDTH-1:0]            vld;
  logic [2:0][ROOT_WIDTH-1:0]       rem_q [QUOT_WIDTH];
  logic [2:0][QUOT_WIDTH-1:0]       quo_q [QUOT_WIDTH];
  logic [ROOT_WIDTH-1:0]            len_q [QUOT_WIDTH];
  norm_t                            norm_q [QUOT_WIDTH];
  logic [2:0][ROOT_WIDTH-1:0]       rem_next [QUOT_WIDTH];
  logic [2:0][QUOT_WIDTH-1:0]       quo_next [QUOT_WIDTH];

  always_comb begin
    logic [ROOT_WIDTH-1:0]     r_in;
    logic [QUOT_WIDTH-1:0]     q_in;
    logic [ROOT_WIDTH-1:0]     d_in;
    norm_t                     n_in;
    logic [DIVIDEND_WIDTH-1:0] dvd;
    logic [ROOT_WIDTH:0]       sh;
    for (int k = 0; k < QUOT_WIDTH; k++) begin
      if (k == 0) begin
        n_in = in_norm;
        d_in = len;
      end else begin
        n_in = norm_q[k-1];
        d_in = len_q[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        dvd = {n_in.m[l], {UNIT_SHIFT{1'b0}}};
        if (k == 0) begin
          r_in = ROOT_WIDTH'(dvd >> QUOT_WIDTH);
          q_in = '0;
        end else begin
          r_in = rem_q[k-1][l];
          q_in = quo_q[k-1][l];
        end
        sh = {r_in, dvd[QUOT_WIDTH-1-k]};
        if (sh >= {1'b0, d_in}) begin
          rem_next[k][l] = ROOT_WIDTH'(sh - {1'b0, d_in});
          quo_next[k][l] = q_in | (QUOT_WIDTH'(1) << (QUOT_WIDTH - 1 - k));
        end else begin
          rem_next[k][l] = sh[ROOT_WIDTH-1:0];
          quo_next[k][l] = q_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUOT_WIDTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUOT_WIDTH; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
        len_q[k] <= (k == 0) ? len : len_q[k-1];
        norm_q[k] <= (k == 0) ? in_norm : norm_q[k-1];
      end
    end
  end

  assign out_valid = vld[QUOT_WIDTH-1];
  assign quo = quo_q[QUOT_WIDTH-1];
  assign out_side = norm_q[QUOT_WIDTH-1].side;

`ifndef SYNTHESIS
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && len_q[QUOT_WIDTH-1] != '0 |->
      rem_q[QUOT_WIDTH-1][0] < len_q[QUOT_WIDTH-1] &&
      rem_q[QUOT_WIDTH-1][1] < len_q[QUOT_WIDTH-1] &&
      rem_q[QUOT_WIDTH-1][2] < len_q[QUOT_WIDTH-1])
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> hdl/pressure_traction_from_triangle.sv
// Top level: input skid stage, normal pipeline, traction multiply and saturating output.
//
//   port group                       | role
//   point_valid/point_stall/point    | quadrature point items in
//   result_valid/result_stall/result | traction items out
//
// One item enters per cycle while the result is not stalled.
// The depth is set by the 32-stage square root and the 31-stage divider.
// Reset clears all valid bits and the skid stage; payload registers are not reset.
// A stalled result freezes the whole pipeline; the skid stage still takes one more item.
module pressure_traction_from_triangle (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  ptt_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_stall,
  output ptt_pkg::result_t result
);
  import ptt_pkg::*;

  logic    en;
  logic    skid_valid;
  point_t  skid_item;
  logic    src_valid;
  point_t  src_item;

  logic                  front_valid;
  logic [SUM_WIDTH-1:0]  front_sum;
  norm_t                 front_norm;
  logic                  sq_valid;
  logic [ROOT_WIDTH-1:0] sq_root;
  norm_t                 sq_norm;
  logic                  div_valid;
  logic [2:0][QUOT_WIDTH-1:0] div_quo;
  side_t                 div_side;

  logic                       prod_valid;
  logic [TRAC_PROD_WIDTH-1:0] prod_q [3];
  side_t                      prod_side;
  result_t                    result_next;

  assign en = ~result_valid | ~result_stall;
  assign point_stall = skid_valid;
  assign src_valid = skid_valid | point_valid;
  assign src_item = skid_valid ? skid_item : point;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (point_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && point_valid && !skid_valid) begin
      skid_item <= point;
    end
  end

  ptt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (src_valid),
    .in_item   (src_item),
    .out_valid (front_valid),
    .sum       (front_sum),
    .out_norm  (front_norm)
  );

  ptt_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .x         (front_sum),
    .in_norm   (front_norm),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_norm  (sq_norm)
  );

  ptt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .len       (sq_root),
    .in_norm   (sq_norm),
    .out_valid (div_valid),
    .quo       (div_quo),
    .out_side  (div_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= div_side.dmag * div_quo[i];
      end
      prod_side <= div_side;
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= div_valid;
      result_valid <= prod_valid;
    end
  end

  always_comb begin
    logic [TRAC_PROD_WIDTH:0]  rnd;
    logic [MAG_WIDTH-1:0]      mag;
    logic [MAG_WIDTH-1:0]      lim;
    logic [MAG_WIDTH-1:0]      val;
    logic                      neg;
    logic                      sat_any;
    logic [PRESSURE_WIDTH-1:0] comp [3];
    sat_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd = (TRAC_PROD_WIDTH+1)'(prod_q[i])
          + ((TRAC_PROD_WIDTH+1)'(1) << (UNIT_SHIFT - 1));
      mag = rnd[TRAC_PROD_WIDTH:UNIT_SHIFT];
      neg = prod_side.dneg ^ prod_side.cneg[i];
      lim = neg ? LIM_NEG : LIM_POS;
      if (mag > lim) begin
        mag = lim;
        sat_any = 1'b1;
      end
      val = neg ? (MAG_WIDTH'(0) - mag) : mag;
      comp[i] = val[PRESSURE_WIDTH-1:0];
    end
    result_next.result_id = prod_side.id;
    if (prod_side.deg) begin
      result_next.traction_x = '0;
      result_next.traction_y = '0;
      result_next.traction_z = '0;
      result_next.status = ST_DEGEN;
    end else begin
      result_next.traction_x = comp[0];
      result_next.traction_y = comp[1];
      result_next.traction_z = comp[2];
      result_next.status = sat_any ? ST_SAT : ST_OK;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_DEGEN |->
      result.traction_x == '0 && result.traction_y == '0 && result.traction_z == '0)
    else $error("degenerate item with nonzero traction");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_SAT |->
      result.traction_x == TRAC_MAX || result.traction_x == TRAC_MIN ||
      result.traction_y == TRAC_MAX || result.traction_y == TRAC_MIN ||
      result.traction_z == TRAC_MAX || result.traction_z == TRAC_MIN)
    else $error("saturated item without a clamped component");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !en |=> skid_valid && $stable(skid_item))
    else $error("skid item lost while pipeline stalled");
`endif

endmodule

>>> tb/sv/pressure_traction_from_triangle_checker.sv
// Checker that predicts the traction for each accepted point and compares every result item.
module pressure_traction_from_triangle_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  input  logic             point_stall,
  input  ptt_pkg::point_t  point,
  input  logic             result_valid,
  input  logic             result_stall,
  input  ptt_pkg::result_t result,
  output int               fail_count,
  output int               pending
);
  import ptt_pkg::*;

  localparam int RING_DEPTH = 256;

  result_t want_ring [RING_DEPTH];
  int      wr_count;
  int      rd_count;

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic result_t traction_of(point_t p);
    logic signed [127:0] e1[3], e2[3], c[3];
    logic [127:0] cm[3], prod, t;
    logic [63:0] m[3], sum, len, nmag, dmag, lim;
    logic cn[3];
    logic neg;
    longint diff;
    int top;
    result_t r;
    e1[0] = longint'(p.v1_x) - longint'(p.v0_x);
    e1[1] = longint'(p.v1_y) - longint'(p.v0_y);
    e1[2] = longint'(p.v1_z) - longint'(p.v0_z);
    e2[0] = longint'(p.v2_x) - longint'(p.v0_x);
    e2[1] = longint'(p.v2_y) - longint'(p.v0_y);
    e2[2] = longint'(p.v2_z) - longint'(p.v0_z);
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.result_id = p.point_id;
    r.traction_x = '0;
    r.traction_y = '0;
    r.traction_z = '0;
    r.status = ST_OK;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      cn[i] = c[i] < 0;
      cm[i] = cn[i] ? -c[i] : c[i];
      for (int b = 127; b >= 0; b--) begin
        if (cm[i][b] && b + 1 > top) top = b + 1;
      end
    end
    if (top == 0) begin
      r.status = ST_DEGEN;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      if (top >= 31) m[i] = 64'(cm[i] >> (top - 31));
      else m[i] = 64'(cm[i] << (31 - top));
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = root_floor(sum);
    diff = longint'(p.pressure_negative) - longint'(p.pressure_positive);
    dmag = diff < 0 ? 64'(-diff) : 64'(diff);
    for (int i = 0; i < 3; i++) begin
      nmag = (m[i] << 30) / len;
      prod = 128'(dmag) * 128'(nmag) + (128'd1 << 29);
      t = prod >> 30;
      neg = (diff < 0) != cn[i];
      lim = neg ? 64'd1 << 31 : (64'd1 << 31) - 1;
      if (t > 128'(lim)) begin
        t = 128'(lim);
        r.status = ST_SAT;
      end
      if (neg) t = -t;
      case (i)
        0: r.traction_x = t[31:0];
        1: r.traction_y = t[31:0];
        default: r.traction_z = t[31:0];
      endcase
    end
    return r;
  endfunction

  assign pending = wr_count - rd_count;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fail_count <= 0;
      wr_count = 0;
      rd_count = 0;
    end else begin
      if (point_valid && !point_stall) begin
        want_ring[wr_count % RING_DEPTH] = traction_of(point);
        wr_count = wr_count + 1;
      end
      if (result_valid && !result_stall) begin
        if (wr_count == rd_count) begin
          $error("Result item with id %0h arrived with nothing expected.", result.result_id);
          fail_count <= fail_count + 1;
        end else begin
          want = want_ring[rd_count % RING_DEPTH];
          rd_count = rd_count + 1;
          if (result != want) fail_count <= fail_count + 1;
          if (result.result_id != want.result_id)
            $error("result_id: expected %0h, got %0h", want.result_id, result.result_id);
          if (result.traction_x != want.traction_x)
            $error("traction_x: expected %0d, got %0d", want.traction_x, result.traction_x);
          if (result.traction_y != want.traction_y)
            $error("traction_y: expected %0d, got %0d", want.traction_y, result.traction_y);
          if (result.traction_z != want.traction_z)
            $error("traction_z: expected %0d, got %0d", want.traction_z, result.traction_z);
          if (result.status != want.status)
            $error("status: expected %0d, got %0d", want.status, result.status);
        end
      end
    end
  end
endmodule

>>> tb/sv/pressure_traction_from_triangle_test.sv
// Testbench top that drives points into the traction block and reports the verdict.
module pressure_traction_from_triangle_test;
  import ptt_pkg::*;

  logic clk, rst;
  logic point_valid, point_stall, result_valid, result_stall;
  point_t point;
  result_t result;
  int fail_count, pending;
  logic took;
  logic calm;
  int serial;

  pressure_traction_from_triangle dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  pressure_traction_from_triangle_checker checker_i (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) took <= !rst && point_valid && !point_stall;

  always @(negedge clk) begin
    if (rst) result_stall <= 0;
    else result_stall <= !calm && $urandom_range(99) < 17;
  end

  task automatic send(input point_t p);
    while (!calm && $urandom_range(99) < 17) begin
      point_valid <= 0;
      @(negedge clk);
    end
    p.point_id = p.point_id ^ serial;
    serial++;
    point_valid <= 1;
    point <= p;
    @(negedge clk);
    while (!took) @(negedge clk);
  endtask

  function automatic point_t tri_of(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] pn, logic [31:0] pp);
    point_t p;
    p.point_id = $urandom();
    {p.v0_x, p.v0_y, p.v0_z} = {32'sd0, 32'sd0, 32'sd0};
    {p.v1_x, p.v1_y, p.v1_z} = {a, 32'sd0, 32'sd0};
    {p.v2_x, p.v2_y, p.v2_z} = {32'sd0, b, c};
    p.pressure_negative = pn;
    p.pressure_positive = pp;
    return p;
  endfunction

  function automatic point_t random_point(int shape);
    point_t p;
    logic signed [31:0] span;
    p = point_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    if (shape < 60) begin
      span = 32'sd1 <<< $urandom_range(24, 2);
      p.v1_x = p.v0_x + $signed($urandom()) % span;
      p.v1_y = p.v0_y + $signed($urandom()) % span;
      p.v1_z = p.v0_z + $signed($urandom()) % span;
      p.v2_x = p.v0_x + $signed($urandom()) % span;
      p.v2_y = p.v0_y + $signed($urandom()) % span;
      p.v2_z = p.v0_z + $signed($urandom()) % span;
      p.pressure_negative = $signed(p.pressure_negative) >>> $urandom_range(20);
      p.pressure_positive = $signed(p.pressure_positive) >>> $urandom_range(20);
    end else if (shape < 68) begin
      {p.v2_x, p.v2_y, p.v2_z} = {p.v1_x, p.v1_y, p.v1_z};
    end else if (shape < 74) begin
      p.pressure_positive = p.pressure_negative;
    end
    return p;
  endfunction

  initial begin
    rst = 1;
    calm = 0;
    serial = 0;
    point_valid = 0;
    point = '0;
    result_stall = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send(tri_of(32'sd0, 32'sd0, 32'sd0, 32'sd256, 32'sd0));
    send(tri_of(32'sd65536, 32'sd65536, 32'sd0, 32'sd25600, 32'sd0));
    send(tri_of(32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd25600));
    send(tri_of(32'sd65536, 32'sd65536, 32'sd65536, -32'sd999, 32'sd12345));
    send(tri_of(32'sd1, 32'sd1, 32'sd0, 32'sd1, 32'sd0));
    send(tri_of(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd2));
    send(tri_of(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send(tri_of(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    send(tri_of(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd0));
    send(tri_of(32'sd3, 32'sd5, 32'sd7, 32'sh80000000, 32'sd0));
    send(tri_of(32'sd3, 32'sd5, 32'sd7, 32'sh40000000, 32'shc0000000));
    send(tri_of(32'sd3, 32'sd5, 32'sd7, 32'sd100, 32'sd100));
    send(tri_of(32'sh7fffffff, 32'sd1, 32'sd0, 32'sh7fffffff, 32'sd0));
    send(tri_of(32'sd65536, 32'sd0, 32'sd0, 32'sd777, 32'sd1));
    send(tri_of(-32'sd65536, 32'sd65536, -32'sd65536, 32'sd5000, -32'sd5000));
    send(random_point(70));
    send(random_point(62));
    send(random_point(99));
    for (int k = 0; k < 1900; k++) begin
      calm = k >= 600 && k < 900;
      if (k == 1000) begin
        point_valid <= 0;
        do @(negedge clk); while (pending != 0);
      end
      send(random_point($urandom_range(99)));
    end
    point_valid <= 0;
    calm = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
